// ===== src/odq_pkg.sv =====
// Shared widths, register codes and the Bayer threshold function of the ordered dither block.
package odq_pkg;

   localparam int PIX_W        = 16;
   localparam int COORD_W      = 16;
   localparam int POS_W        = 4;
   localparam int THR_W        = 8;
   localparam int LEVEL_W      = 8;
   localparam int OUT_W        = 8;
   localparam int DIV_STEPS    = 8;
   // Product, level estimate, level clamp and numerator stages, then the divider steps.
   localparam int CHAN_STAGES  = 4 + DIV_STEPS;
   localparam int POS_STAGES   = 2;

   localparam int DEF_MATRIX_SIZE = 16;

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic [0:0] CSR_LEVEL_STEPS = 1'b0;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 8'd1;

   // Threshold of the 16x16 Bayer matrix at the given column and row.
   function automatic logic [THR_W-1:0] bayer_threshold(input logic [POS_W-1:0] col,
                                                         input logic [POS_W-1:0] row);
      logic [THR_W-1:0] v;
      v = '0;
      for (int i = 0; i < POS_W; i++) begin
         v[THR_W-1-2*i] = col[i] ^ row[i];
         v[THR_W-2-2*i] = row[i];
      end
      return v;
   endfunction

endpackage

// ===== src/odq_req_if.sv =====
// Pixel input channel: valid, ready and one pixel with its position.
interface odq_req_if;
   import odq_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   red_in;
   logic [PIX_W-1:0]   green_in;
   logic [PIX_W-1:0]   blue_in;
   logic [COORD_W-1:0] pixel_col;
   logic [COORD_W-1:0] pixel_row;

   modport source (output valid, red_in, green_in, blue_in, pixel_col, pixel_row,
                   input ready);
   modport sink   (input valid, red_in, green_in, blue_in, pixel_col, pixel_row,
                   output ready);
endinterface

// ===== src/odq_rsp_if.sv =====
// Result channel: valid, ready and one dithered RGB byte triple.
interface odq_rsp_if;
   import odq_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] red_out;
   logic [OUT_W-1:0] green_out;
   logic [OUT_W-1:0] blue_out;

   modport source (output valid, red_out, green_out, blue_out, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== src/ordered_dither_rgb_top.sv =====
// Top level of the ordered Bayer dither block for RGB pixels.
//
//   channel   role    handshake             payload
//   req_chan  input   valid/ready           red_in, green_in, blue_in, pixel_col, pixel_row
//   rsp_chan  output  valid/ready           red_out, green_out, blue_out
//   csr_*     config  APB, pready always 1  level_steps at byte address 0
//
// One item enters per clock while rsp_chan does not stall, and passes 14 register stages:
// two position stages (matrix modulo and threshold lookup), four arithmetic stages and
// the eight steps of the per-channel restoring divider.
// Reset clears all stage valid bits and sets level_steps to 1.
// A stall on rsp_chan holds the full stages that have no empty stage after them;
// others advance into the gaps, so req_chan stays ready until every stage holds an item.
module ordered_dither_rgb_top #(
   parameter int MATRIX_SIZE = odq_pkg::DEF_MATRIX_SIZE
) (
   input  logic                            clock,
   input  logic                            reset,
   odq_req_if.sink                         req_chan,
   odq_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [odq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [odq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [odq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import odq_pkg::*;

   localparam int NSTG        = POS_STAGES + CHAN_STAGES;
   localparam int RECIP_SHIFT = COORD_W + POS_W;
   localparam int RECIP       = (1 << RECIP_SHIFT) / MATRIX_SIZE;
   localparam int MPROD_W     = COORD_W + RECIP_SHIFT;

   logic [LEVEL_W-1:0]             level_ff, level_in;
   logic                           csr_write;

   logic [NSTG-1:0]                v_ff, v_in;
   logic [NSTG-1:0]                en;

   logic [MPROD_W-1:0]             col_prod, row_prod;
   logic [COORD_W-1:0]             col_ff, row_ff, qc_ff, qr_ff, qc_in, qr_in;
   logic [COORD_W-1:0]             col_rem, row_rem, col_fix, row_fix;
   logic [THR_W-1:0]               t_ff, t_in;
   logic [2:0][PIX_W-1:0]          x0_ff, x1_ff;
   logic [2:0][OUT_W-1:0]          chan_out;

   // Configuration register.
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_LEVEL_STEPS) ? CSR_DATA_W'(level_ff) : '0;

   always_comb begin
      level_in = level_ff;
      if (csr_write && csr_paddr[2] == CSR_LEVEL_STEPS) begin
         level_in = csr_pwdata[LEVEL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_RESET;
      end else begin
         level_ff <= level_in;
      end
   end

   // A stage may load when it or some stage after it is empty, or the output is taken.
   genvar g;
   generate
      for (g = 0; g < NSTG; g++) begin : g_en
         assign en[g] = rsp_chan.ready || !(&v_ff[NSTG-1:g]);
      end
   endgenerate

   assign v_in = {v_ff[NSTG-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_in[i];
            end
         end
      end
   end

   assign req_chan.ready = en[0];

   // Position modulo the matrix size: the reciprocal quotient is at most one low.
   always_comb begin
      col_prod = MPROD_W'(req_chan.pixel_col) * MPROD_W'(RECIP);
      row_prod = MPROD_W'(req_chan.pixel_row) * MPROD_W'(RECIP);
      qc_in    = col_prod[MPROD_W-1:RECIP_SHIFT];
      qr_in    = row_prod[MPROD_W-1:RECIP_SHIFT];

      col_rem  = col_ff - COORD_W'(qc_ff * COORD_W'(MATRIX_SIZE));
      row_rem  = row_ff - COORD_W'(qr_ff * COORD_W'(MATRIX_SIZE));
      col_fix  = (col_rem >= COORD_W'(MATRIX_SIZE)) ? col_rem - COORD_W'(MATRIX_SIZE) : col_rem;
      row_fix  = (row_rem >= COORD_W'(MATRIX_SIZE)) ? row_rem - COORD_W'(MATRIX_SIZE) : row_rem;
      t_in     = bayer_threshold(col_fix[POS_W-1:0], row_fix[POS_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         col_ff   <= req_chan.pixel_col;
         row_ff   <= req_chan.pixel_row;
         qc_ff    <= qc_in;
         qr_ff    <= qr_in;
         x0_ff[0] <= req_chan.red_in;
         x0_ff[1] <= req_chan.green_in;
         x0_ff[2] <= req_chan.blue_in;
      end
      if (en[1]) begin
         t_ff  <= t_in;
         x1_ff <= x0_ff;
      end
   end

   generate
      for (g = 0; g < 3; g++) begin : g_chan
         odq_channel u_chan (
            .clock       (clock),
            .stage_en    (en[NSTG-1:POS_STAGES]),
            .pix_in      (x1_ff[g]),
            .thr_in      (t_ff),
            .level_steps (level_ff),
            .byte_out    (chan_out[g])
         );
      end
   endgenerate

   assign rsp_chan.valid     = v_ff[NSTG-1];
   assign rsp_chan.red_out   = chan_out[0];
   assign rsp_chan.green_out = chan_out[1];
   assign rsp_chan.blue_out  = chan_out[2];

endmodule

// ===== src/odq_channel.sv =====
// Pipelined quantizer of one color channel: level index, clamp and restoring divider.
module odq_channel (
   input  logic                              clock,
   input  logic [odq_pkg::CHAN_STAGES-1:0]   stage_en,
   input  logic [odq_pkg::PIX_W-1:0]         pix_in,
   input  logic [odq_pkg::THR_W-1:0]         thr_in,
   input  logic [odq_pkg::LEVEL_W-1:0]       level_steps,
   output logic [odq_pkg::OUT_W-1:0]         byte_out
);
   import odq_pkg::*;

   localparam int PROD_W = PIX_W + LEVEL_W;
   localparam int QUO_W  = PROD_W - 8;
   localparam int EST_W  = 9;
   localparam int NUM_W  = 16;

   logic [PROD_W-1:0]                  prod_ff, prod_in;
   logic [QUO_W-1:0]                   quo_ff, quo_in;
   logic [EST_W-1:0]                   est_ff, est_in;
   logic [QUO_W+EST_W-1:0]             est_prod;
   logic [QUO_W:0]                     rem;
   logic [EST_W-1:0]                   lvl_raw;
   logic [LEVEL_W-1:0]                 lvl_ff, lvl_in;
   logic [NUM_W-1:0]                   num_ff, num_in;
   logic [DIV_STEPS-1:0][NUM_W-1:0]    work_ff, work_in;
   logic [DIV_STEPS-1:0][NUM_W-1:0]    div_src;
   logic [DIV_STEPS-1:0][LEVEL_W:0]    div_trial;
   logic [DIV_STEPS-1:0][LEVEL_W:0]    div_diff;

   always_comb begin
      // P = x*L + t*255; the level index is floor(P / 65280).
      prod_in  = PROD_W'(pix_in) * PROD_W'(level_steps) + PROD_W'(thr_in) * PROD_W'(255);

      // floor(Q / 255) with Q = P / 256, estimated by Q*257 / 65536 and
      // corrected once below.
      quo_in   = prod_ff[PROD_W-1:8];
      est_prod = (QUO_W+EST_W)'(quo_in) * (QUO_W+EST_W)'(257);
      est_in   = est_prod[QUO_W+EST_W-1:16];

      rem      = (QUO_W+1)'(quo_ff) - (QUO_W+1)'(est_ff) * (QUO_W+1)'(255);
      lvl_raw  = est_ff + EST_W'(rem >= (QUO_W+1)'(255));
      lvl_in   = (lvl_raw > EST_W'(level_steps)) ? level_steps : lvl_raw[LEVEL_W-1:0];

      // round-half-up(k*255/L) equals floor((255k + floor(L/2)) / L).
      num_in   = NUM_W'(lvl_ff) * NUM_W'(255) + NUM_W'(level_steps[LEVEL_W-1:1]);

      // One quotient bit per stage; the upper byte holds the partial remainder.
      for (int j = 0; j < DIV_STEPS; j++) begin
         div_src[j]   = (j == 0) ? num_ff : work_ff[(j == 0) ? 0 : j-1];
         div_trial[j] = {div_src[j][NUM_W-1:8], div_src[j][7]};
         div_diff[j]  = div_trial[j] - {1'b0, level_steps};
         if (div_trial[j] >= {1'b0, level_steps}) begin
            work_in[j] = {div_diff[j][LEVEL_W-1:0], div_src[j][6:0], 1'b1};
         end else begin
            work_in[j] = {div_trial[j][LEVEL_W-1:0], div_src[j][6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[1]) begin
         quo_ff <= quo_in;
         est_ff <= est_in;
      end
      if (stage_en[2]) begin
         lvl_ff <= lvl_in;
      end
      if (stage_en[3]) begin
         num_ff <= num_in;
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (stage_en[4+j]) begin
            work_ff[j] <= work_in[j];
         end
      end
   end

   // With zero steps every level clamps to zero and the output is zero.
   assign byte_out = (level_steps == '0) ? '0 : work_ff[DIV_STEPS-1][OUT_W-1:0];

endmodule

// ===== tb/ordered_dither_rgb_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the ordered Bayer dither block: pixel stimulus, APB setup, result checks.
module ordered_dither_rgb_top_test;
   import odq_pkg::*;

   localparam int DITHER_MATRIX      = 16;
   localparam int unsigned FULL_SCALE = 255;
   localparam int unsigned DIV_SPAN   = 65280;  // 255 * 256
   localparam int CSR_UNUSED_INDEX   = 1;
   localparam int SEGMENTS           = 7;
   localparam int PIXELS_PER_SEGMENT = 300;
   localparam int DRAIN_SLACK        = 20;
   localparam int LIMIT_CYCLES       = 500000;
   localparam int REPORT_MAX         = 10;

   typedef struct packed {
      logic [PIX_W-1:0]   red;
      logic [PIX_W-1:0]   green;
      logic [PIX_W-1:0]   blue;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } pixel_t;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } rgb_t;

   // Keeps the expected dithered triples in order and compares each result against them.
   class dither_scoreboard;
      logic [LEVEL_W-1:0] level_steps;
      rgb_t               expected_rgb_q[$];
      int unsigned        mismatches;

      function new();
         level_steps = LEVEL_RESET;
         mismatches  = 0;
      endfunction

      function void write_register(int unsigned index, logic [CSR_DATA_W-1:0] value);
         if (index == CSR_LEVEL_STEPS)
            level_steps = value[LEVEL_W-1:0];
      endfunction

      // The first position bit lands in the top two bits of the threshold.
      function logic [THR_W-1:0] bayer_level(logic [POS_W-1:0] col, logic [POS_W-1:0] row);
         logic [THR_W-1:0] v;
         v = '0;
         for (int i = 0; i < POS_W; i++)
            v = {v[THR_W-3:0], col[i] ^ row[i], row[i]};
         return v;
      endfunction

      // The rounded level index is floor((x*L + t*255) / 65280), clamped to L.
      function logic [OUT_W-1:0] dither_channel(logic [PIX_W-1:0] x, logic [THR_W-1:0] t,
                                                logic [LEVEL_W-1:0] steps);
         int unsigned p;
         int unsigned k;
         p = 32'(x) * 32'(steps) + 32'(t) * FULL_SCALE;
         k = p / DIV_SPAN;
         if (k > 32'(steps))
            k = 32'(steps);
         if (steps == 0)
            return '0;
         return OUT_W'((2 * FULL_SCALE * k + 32'(steps)) / (2 * 32'(steps)));
      endfunction

      function void note_pixel(pixel_t px);
         logic [THR_W-1:0] t;
         rgb_t             exp_rgb;
         t = bayer_level(POS_W'(px.col % DITHER_MATRIX), POS_W'(px.row % DITHER_MATRIX));
         exp_rgb.red   = dither_channel(px.red,   t, level_steps);
         exp_rgb.green = dither_channel(px.green, t, level_steps);
         exp_rgb.blue  = dither_channel(px.blue,  t, level_steps);
         expected_rgb_q.push_back(exp_rgb);
      endfunction

      function void check_result(rgb_t got);
         rgb_t exp_rgb;
         if (expected_rgb_q.size() == 0) begin
            if (mismatches < REPORT_MAX)
               $display("unexpected result r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
            mismatches++;
            return;
         end
         exp_rgb = expected_rgb_q.pop_front();
         if (got.red != exp_rgb.red || got.green != exp_rgb.green
             || got.blue != exp_rgb.blue) begin
            if (mismatches < REPORT_MAX)
               $display("result mismatch at L=%0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                        level_steps, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                        got.red, got.green, got.blue);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_rgb_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    src_idle_pct;
   int                    sink_stall_pct;
   int unsigned           cycle_count = 0;
   logic [LEVEL_W-1:0]    level_plan [SEGMENTS] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd0, 8'd7, 8'd128};

   dither_scoreboard sb = new();

   odq_req_if req_chan();
   odq_rsp_if rsp_chan();

   ordered_dither_rgb_top #(.MATRIX_SIZE(DITHER_MATRIX)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Both handshakes are judged on the values present just before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_pixel('{req_chan.red_in, req_chan.green_in, req_chan.blue_in,
                            req_chan.pixel_col, req_chan.pixel_row});
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_result('{rsp_chan.red_out, rsp_chan.green_out, rsp_chan.blue_out});
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES)
         @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [PIX_W-1:0] pick_channel();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 16'hFF00 | PIX_W'($urandom_range(255));  // at or above 255.0
         3: return PIX_W'($urandom_range(255));
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic pixel_t random_pixel();
      pixel_t px;
      px.red   = pick_channel();
      px.green = pick_channel();
      px.blue  = pick_channel();
      px.col   = COORD_W'($urandom_range(65535));
      px.row   = COORD_W'($urandom_range(65535));
      return px;
   endfunction

   // Leaves valid high after acceptance; the next call either replaces the item or drops valid.
   task automatic send_pixel(input pixel_t px);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.red_in    <= px.red;
      req_chan.green_in  <= px.green;
      req_chan.blue_in   <= px.blue;
      req_chan.pixel_col <= px.col;
      req_chan.pixel_row <= px.row;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic csr_write(input int unsigned index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(index * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_register(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // The first edge lets the monitor record the item accepted at the last edge.
   task automatic wait_drained();
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic send_directed();
      send_pixel('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
      send_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h000F, 16'h000F});
      send_pixel('{16'hFF00, 16'hFF01, 16'hFEFF, 16'h0001, 16'h0000});
      send_pixel('{16'h8000, 16'h7FFF, 16'h0080, 16'h0000, 16'h0001});
      send_pixel('{16'h0100, 16'h0001, 16'h00FF, 16'hFFFF, 16'hFFFF});
      send_pixel('{16'hFF00, 16'h0000, 16'hFFFF, 16'hFFF0, 16'h000F});
      send_pixel('{16'h4000, 16'hC000, 16'h2000, 16'h1234, 16'h5678});
      send_pixel('{16'h5555, 16'hAAAA, 16'h0F0F, 16'hAAAA, 16'h5555});
      send_pixel('{16'hAAAA, 16'h5555, 16'hF0F0, 16'h5555, 16'hAAAA});
      // Mid-gray across several thresholds, where the dither decides the level.
      for (int i = 0; i < 8; i++)
         send_pixel('{16'h7F80, 16'h8000, 16'h7F00, COORD_W'(2 * i + 1), COORD_W'(2 * i)});
   endtask

   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.red_in    <= '0;
      req_chan.green_in  <= '0;
      req_chan.blue_in   <= '0;
      req_chan.pixel_col <= '0;
      req_chan.pixel_row <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      src_idle_pct       = 16;
      sink_stall_pct     = 56;
      level_plan[4]      = LEVEL_W'($urandom_range(254, 3));
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int s = 0; s < SEGMENTS; s++) begin
         if (s < 3) begin
            src_idle_pct   = 16;
            sink_stall_pct = 56;
         end else if (s < 5) begin
            src_idle_pct   = 56;
            sink_stall_pct = 16;
         end else begin
            src_idle_pct   = 0;
            sink_stall_pct = 0;
         end
         if (s == 0) begin
            // The reset value of level_steps is exercised first.
            send_directed();
         end else begin
            if (s == 3)
               csr_write(CSR_UNUSED_INDEX, 32'h0000_0005);
            csr_write(CSR_LEVEL_STEPS, {8'($urandom_range(255)), 16'h0000, level_plan[s]});
         end
         repeat (PIXELS_PER_SEGMENT) send_pixel(random_pixel());
         req_chan.valid <= 1'b0;
         wait_drained();
      end

      repeat (DRAIN_SLACK) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/odq_pkg.sv
src/odq_req_if.sv
src/odq_rsp_if.sv
src/odq_channel.sv
src/ordered_dither_rgb_top.sv
tb/ordered_dither_rgb_top_test.sv
